[rtl/core/power_loss_burst_scheduler_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef POWER_LOSS_BURST_SCHEDULER_MACROS_SVH
`define POWER_LOSS_BURST_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("power_loss_burst_scheduler: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PLBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("power_loss_burst_scheduler: next-cycle check failed");

`endif

[rtl/core/plbs_pkg.sv]
package plbs_pkg;

    // Result command codes.
    typedef enum logic [1:0] {
        ACT_NORMAL     = 2'd0,
        ACT_BURST_SEND = 2'd1,
        ACT_LOW_POWER  = 2'd2
    } action_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_POWER_ON_DEBOUNCE  = 3'd0,
        REG_POWER_OFF_DEBOUNCE = 3'd1,
        REG_BURST_LENGTH       = 3'd2,
        REG_BURST_SPACING      = 3'd3,
        REG_REARM_COOLDOWN     = 3'd4,
        REG_LOW_POWER_INTERVAL = 3'd5,
        REG_NORMAL_INTERVAL    = 3'd6
    } reg_index_t;

    // Register defaults after reset.
    localparam logic [15:0] POWER_ON_DEBOUNCE_RST  = 16'd10;
    localparam logic [15:0] POWER_OFF_DEBOUNCE_RST = 16'd10;
    localparam logic [7:0]  BURST_LENGTH_RST       = 8'd3;
    localparam logic [15:0] BURST_SPACING_RST      = 16'd30;
    localparam logic [15:0] REARM_COOLDOWN_RST     = 16'd600;
    localparam logic [31:0] LOW_POWER_INTERVAL_RST = 32'd900;
    localparam logic [31:0] NORMAL_INTERVAL_RST    = 32'd120;

    // Update interval carried by a burst send.
    localparam logic [31:0] BURST_SEND_INTERVAL = 32'd1;

    // Send jitter is the current time modulo this value.
    localparam int unsigned JITTER_MOD = 15;

    // Output queue depth (a tick yields at most three results).
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [31:0] now_seconds;
        logic        power_present;
    } tick_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] update_interval;
        logic        saving_mode;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [2:0]  reg_index;
        logic [31:0] reg_data;
    } cfg_write_t;

endpackage

[rtl/core/plbs_stream_if.sv]
interface plbs_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/power_loss_burst_scheduler.sv]
// A tick is captured in the input register, evaluated from it, and its results are
// written to the output queue once the queue has room for them; the first result is then
// offered from the queue. Ticks are taken one per cycle while output space allows;
// results leave one beat per cycle, while the receiver is ready, from a four-entry queue.
// Reset (rst_n, asynchronous, active low) clears all state and the queue and loads the
// register defaults; no clearing pass follows.
`include "power_loss_burst_scheduler_macros.svh"

module power_loss_burst_scheduler #(
    parameter int TIME_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    plbs_stream_if.sink   tick,
    plbs_stream_if.source result,
    plbs_stream_if.sink   cfg
);
    import plbs_pkg::*;

    localparam int NIB    = (TIME_BITS + 3) / 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Time modulo 15: 16 is 1 mod 15, so nibble sums keep the residue.
    function automatic logic [3:0] mod15(input logic [NIB*4-1:0] v);
        logic [7:0] s;
        logic [4:0] t;
        logic [4:0] r;
        s = '0;
        for (int i = 0; i < NIB; i++) begin
            s = s + 8'(v[i*4 +: 4]);
        end
        t = 5'(s[7:4]) + 5'(s[3:0]);
        r = (t >= 5'(JITTER_MOD)) ? t - 5'(JITTER_MOD) : t;
        if (r == 5'(JITTER_MOD)) begin
            r = '0;
        end
        return r[3:0];
    endfunction

    // Configuration registers.
    logic [15:0] power_on_debounce_reg;
    logic [15:0] power_off_debounce_reg;
    logic [7:0]  burst_length_reg;
    logic [15:0] burst_spacing_reg;
    logic [15:0] rearm_cooldown_reg;
    logic [31:0] low_power_interval_reg;
    logic [31:0] normal_interval_reg;

    // Input register.
    logic                 in_valid_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic                 power_reg;
    logic [3:0]           jitter_reg;

    // Scheduler state.
    logic                 prev_power_reg,     prev_power_next;
    logic [TIME_BITS-1:0] on_since_reg,       on_since_next;
    logic [TIME_BITS-1:0] off_since_reg,      off_since_next;
    logic [7:0]           bursts_left_reg,    bursts_left_next;
    logic [TIME_BITS-1:0] next_send_time_reg, next_send_time_next;
    logic [TIME_BITS-1:0] rearm_time_reg,     rearm_time_next;

    // Output queue.
    result_t           q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] q_cnt_reg;

    logic [63:0]          now_wide;
    logic [TIME_BITS-1:0] now_in;
    logic                 tick_beat;
    logic                 result_beat;
    logic                 commit;
    logic [QCNT_W-1:0]    q_free;

    logic [TIME_BITS-1:0] on_cand;
    logic [TIME_BITS-1:0] off_cand;
    logic                 fire_on;
    logic                 arm;
    logic [7:0]           bursts_mid;
    logic [TIME_BITS-1:0] send_mid;
    logic                 send;
    logic                 low;
    logic [1:0]           n_res;
    result_t              res [3];
    result_t              normal_item;
    result_t              send_item;
    result_t              low_item;

    // Time input masked to the time width.
    assign now_wide  = 64'(tick.payload.now_seconds);
    assign now_in    = now_wide[TIME_BITS-1:0];

    assign tick_beat   = tick.valid && tick.ready;
    assign result_beat = result.valid && result.ready;
    assign q_free      = QCNT_W'(QUEUE_DEPTH) - q_cnt_reg;
    assign commit      = in_valid_reg && (QCNT_W'(n_res) <= q_free);

    assign tick.ready     = !in_valid_reg || commit;
    assign cfg.ready      = 1'b1;
    assign result.valid   = (q_cnt_reg != '0);
    assign result.payload = q_reg[rd_ptr_reg];

    // Debounce, arming and burst sends for the registered tick.
    always_comb
    begin
        on_cand             = on_since_reg;
        off_cand            = off_since_reg;
        fire_on             = 1'b0;
        arm                 = 1'b0;
        on_since_next       = on_since_reg;
        off_since_next      = off_since_reg;
        rearm_time_next     = rearm_time_reg;
        if (power_reg)
        begin
            off_since_next = '0;
            if (!prev_power_reg && on_since_reg == '0)
            begin
                on_cand = now_reg;
            end
            fire_on = (on_cand != '0)
                   && ((now_reg - on_cand) >= TIME_BITS'(power_on_debounce_reg));
            on_since_next = fire_on ? '0 : on_cand;
        end
        else
        begin
            on_since_next = '0;
            if (prev_power_reg && off_since_reg == '0)
            begin
                off_cand = now_reg;
            end
            off_since_next = off_cand;
            arm = (off_cand != '0)
               && ((now_reg - off_cand) >= TIME_BITS'(power_off_debounce_reg))
               && (now_reg >= rearm_time_reg) && (bursts_left_reg == '0);
            if (arm)
            begin
                rearm_time_next = now_reg + TIME_BITS'(rearm_cooldown_reg);
            end
        end

        bursts_mid = arm ? burst_length_reg : bursts_left_reg;
        send_mid   = arm ? '0 : next_send_time_reg;
        send = (bursts_mid != '0) && ((send_mid == '0) || (now_reg >= send_mid));
        low  = send && (bursts_mid == 8'd1);
        bursts_left_next    = send ? bursts_mid - 8'd1 : bursts_mid;
        next_send_time_next = (send && !low)
                            ? now_reg + TIME_BITS'(burst_spacing_reg) + TIME_BITS'(jitter_reg)
                            : send_mid;
        prev_power_next = power_reg;
    end

    // Result items in emission order: normal, burst send, low power.
    always_comb
    begin
        normal_item = '{action: ACT_NORMAL, update_interval: normal_interval_reg,
                        saving_mode: 1'b0, last_of_run: 1'b0};
        send_item   = '{action: ACT_BURST_SEND, update_interval: BURST_SEND_INTERVAL,
                        saving_mode: 1'b0, last_of_run: 1'b0};
        low_item    = '{action: ACT_LOW_POWER, update_interval: low_power_interval_reg,
                        saving_mode: 1'b1, last_of_run: 1'b0};
        n_res  = 2'(fire_on) + 2'(send) + 2'(low);
        res[0] = fire_on ? normal_item : send_item;
        res[1] = fire_on ? send_item : low_item;
        res[2] = low_item;
        for (int k = 0; k < 3; k++)
        begin
            res[k].last_of_run = (2'(k) == n_res - 2'd1);
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_on_debounce_reg  <= POWER_ON_DEBOUNCE_RST;
            power_off_debounce_reg <= POWER_OFF_DEBOUNCE_RST;
            burst_length_reg       <= BURST_LENGTH_RST;
            burst_spacing_reg      <= BURST_SPACING_RST;
            rearm_cooldown_reg     <= REARM_COOLDOWN_RST;
            low_power_interval_reg <= LOW_POWER_INTERVAL_RST;
            normal_interval_reg    <= NORMAL_INTERVAL_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.payload.reg_index)
                REG_POWER_ON_DEBOUNCE:  power_on_debounce_reg  <= cfg.payload.reg_data[15:0];
                REG_POWER_OFF_DEBOUNCE: power_off_debounce_reg <= cfg.payload.reg_data[15:0];
                REG_BURST_LENGTH:       burst_length_reg       <= cfg.payload.reg_data[7:0];
                REG_BURST_SPACING:      burst_spacing_reg      <= cfg.payload.reg_data[15:0];
                REG_REARM_COOLDOWN:     rearm_cooldown_reg     <= cfg.payload.reg_data[15:0];
                REG_LOW_POWER_INTERVAL: low_power_interval_reg <= cfg.payload.reg_data;
                REG_NORMAL_INTERVAL:    normal_interval_reg    <= cfg.payload.reg_data;
                default: ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick_beat)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (commit)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input payload; the jitter residue is worked out on the way in.
    always_ff @(posedge clk)
    begin
        if (tick_beat)
        begin
            now_reg    <= now_in;
            power_reg  <= tick.payload.power_present;
            jitter_reg <= mod15((NIB*4)'(now_in));
        end
    end

    // Scheduler state, updated when a tick's results enter the queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_power_reg     <= 1'b0;
            on_since_reg       <= '0;
            off_since_reg      <= '0;
            bursts_left_reg    <= '0;
            next_send_time_reg <= '0;
            rearm_time_reg     <= '0;
        end
        else if (commit)
        begin
            prev_power_reg     <= prev_power_next;
            on_since_reg       <= on_since_next;
            off_since_reg      <= off_since_next;
            bursts_left_reg    <= bursts_left_next;
            next_send_time_reg <= next_send_time_next;
            rearm_time_reg     <= rearm_time_next;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            if (commit)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(n_res);
            end
            if (result_beat)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            q_cnt_reg <= q_cnt_reg + (commit ? QCNT_W'(n_res) : '0)
                       - QCNT_W'(result_beat);
        end
    end

    // Queue entries; a tick writes up to three consecutive slots.
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (2'(k) < n_res)
                begin
                    q_reg[wr_ptr_reg + QPTR_W'(k)] <= res[k];
                end
            end
        end
    end

    // Checks.
    `PLBS_ASSERT_NOW(a_q_cnt_bound, clk, rst_n, 1'b1, q_cnt_reg <= QCNT_W'(QUEUE_DEPTH))
    `PLBS_ASSERT_NEXT(a_push_shows, clk, rst_n, commit && (n_res != 2'd0), q_cnt_reg != '0)
    `PLBS_ASSERT_NEXT(a_low_ends_burst, clk, rst_n, commit && low, bursts_left_reg == '0)
    `PLBS_ASSERT_NOW(a_one_mark, clk, rst_n, 1'b1, (on_since_reg == '0) || (off_since_reg == '0))

endmodule

[sim/plbs_command_checker.sv]
`timescale 1ns / 100ps

module plbs_command_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick_valid,
    input  logic                 tick_ready,
    input  plbs_pkg::tick_t      tick_beat,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  plbs_pkg::result_t    result_beat,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  plbs_pkg::cfg_write_t cfg_beat,
    output int unsigned          mismatches,
    output int unsigned          results_owed
);
    import plbs_pkg::*;

    // Copies of the configuration registers.
    logic [15:0] on_debounce;
    logic [15:0] off_debounce;
    logic [7:0]  burst_len;
    logic [15:0] send_spacing;
    logic [15:0] cooldown;
    logic [31:0] low_power_iv;
    logic [31:0] normal_iv;

    // Scheduler state as the block should hold it.
    logic        last_power;
    logic [31:0] on_mark;
    logic [31:0] off_mark;
    logic [7:0]  sends_left;
    logic [31:0] next_send;
    logic [31:0] rearm_at;

    // Commands predicted but not yet seen on the result channel, oldest first.
    result_t pending_cmds[$];

    function automatic result_t make_cmd(action_t act, logic [31:0] iv, logic saving);
        result_t cmd;
        cmd.action          = act;
        cmd.update_interval = iv;
        cmd.saving_mode     = saving;
        cmd.last_of_run     = 1'b0;
        return cmd;
    endfunction

    task automatic report(input string what);
        mismatches++;
        $display("%0t ns: command mismatch: %s", $time, what);
    endtask

    // Work out the commands one tick causes and advance the scheduler state.
    task automatic schedule_tick(input tick_t t);
        logic [31:0] now;
        result_t     cmds[3];
        int          n;
        now = t.now_seconds;
        n   = 0;

        if (t.power_present) begin
            // Power present: debounce toward the normal profile.
            off_mark = '0;
            if (!last_power && on_mark == 0)
                on_mark = now;
            if (on_mark != 0 && (now - on_mark) >= {16'd0, on_debounce}) begin
                cmds[n] = make_cmd(ACT_NORMAL, normal_iv, 1'b0);
                n++;
                on_mark = '0;
            end
        end
        else begin
            // Power absent: debounce toward arming a burst, subject to cooldown.
            on_mark = '0;
            if (last_power && off_mark == 0)
                off_mark = now;
            if (off_mark != 0 && (now - off_mark) >= {16'd0, off_debounce}) begin
                if (now >= rearm_at && sends_left == 0) begin
                    sends_left = burst_len;
                    next_send  = '0;
                    rearm_at   = now + {16'd0, cooldown};
                end
            end
        end

        // A send is due when no time is set yet or the set time has come.
        if (sends_left != 0 && (next_send == 0 || now >= next_send)) begin
            cmds[n] = make_cmd(ACT_BURST_SEND, BURST_SEND_INTERVAL, 1'b0);
            n++;
            sends_left--;
            if (sends_left == 0) begin
                cmds[n] = make_cmd(ACT_LOW_POWER, low_power_iv, 1'b1);
                n++;
            end
            else begin
                next_send = now + {16'd0, send_spacing} + (now % JITTER_MOD);
            end
        end

        last_power = t.power_present;

        if (n > 0)
            cmds[n - 1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            pending_cmds.push_back(cmds[i]);
    endtask

    // Compare one result beat with the oldest pending command.
    task automatic check_cmd(input result_t got);
        result_t want;
        if (pending_cmds.size() == 0) begin
            report($sformatf("unexpected beat, action %0d interval %0h",
                             got.action, got.update_interval));
        end
        else begin
            want = pending_cmds.pop_front();
            if (got.action !== want.action)
                report($sformatf("action %0d, expected %0d", got.action, want.action));
            if (got.update_interval !== want.update_interval)
                report($sformatf("update_interval %0h, expected %0h",
                                 got.update_interval, want.update_interval));
            if (got.saving_mode !== want.saving_mode)
                report($sformatf("saving_mode %0b, expected %0b",
                                 got.saving_mode, want.saving_mode));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("last_of_run %0b, expected %0b",
                                 got.last_of_run, want.last_of_run));
        end
    endtask

    // Watch all three channels at each rising edge.
    always @(posedge clk) begin
        if (!rst_n) begin
            on_debounce  = POWER_ON_DEBOUNCE_RST;
            off_debounce = POWER_OFF_DEBOUNCE_RST;
            burst_len    = BURST_LENGTH_RST;
            send_spacing = BURST_SPACING_RST;
            cooldown     = REARM_COOLDOWN_RST;
            low_power_iv = LOW_POWER_INTERVAL_RST;
            normal_iv    = NORMAL_INTERVAL_RST;
            last_power   = 1'b0;
            on_mark      = '0;
            off_mark     = '0;
            sends_left   = '0;
            next_send    = '0;
            rearm_at     = '0;
            pending_cmds.delete();
        end
        else begin
            if (result_valid && result_ready)
                check_cmd(result_beat);

            // Register writes keep only the bits each register holds.
            if (cfg_valid && cfg_ready) begin
                case (cfg_beat.reg_index)
                    REG_POWER_ON_DEBOUNCE:  on_debounce  = cfg_beat.reg_data[15:0];
                    REG_POWER_OFF_DEBOUNCE: off_debounce = cfg_beat.reg_data[15:0];
                    REG_BURST_LENGTH:       burst_len    = cfg_beat.reg_data[7:0];
                    REG_BURST_SPACING:      send_spacing = cfg_beat.reg_data[15:0];
                    REG_REARM_COOLDOWN:     cooldown     = cfg_beat.reg_data[15:0];
                    REG_LOW_POWER_INTERVAL: low_power_iv = cfg_beat.reg_data;
                    REG_NORMAL_INTERVAL:    normal_iv    = cfg_beat.reg_data;
                    default: ;
                endcase
            end

            if (tick_valid && tick_ready)
                schedule_tick(tick_beat);
        end
        results_owed <= pending_cmds.size();
    end

endmodule

[sim/tb_power_loss_burst_scheduler.sv]
`timescale 1ns / 100ps

module tb_power_loss_burst_scheduler;
    import plbs_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 40;
    // Index with no register behind it; a write there must change nothing.
    localparam logic [2:0]  REG_UNMAPPED = 3'd7;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    plbs_stream_if #(.payload_t(tick_t))      tick_ch ();
    plbs_stream_if #(.payload_t(result_t))    result_ch ();
    plbs_stream_if #(.payload_t(cfg_write_t)) cfg_ch ();

    int unsigned mismatches;
    int unsigned results_owed;

    // Stimulus controls; stall_on and hold_asks are shared with the receiver.
    bit          idle_on;
    bit          stall_on;
    int unsigned hold_asks;
    logic [31:0] cur_time;
    logic        cur_power;

    power_loss_burst_scheduler uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    plbs_command_checker cmd_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_ch.valid),
        .tick_ready   (tick_ch.ready),
        .tick_beat    (tick_ch.payload),
        .result_valid (result_ch.valid),
        .result_ready (result_ch.ready),
        .result_beat  (result_ch.payload),
        .cfg_valid    (cfg_ch.valid),
        .cfg_ready    (cfg_ch.ready),
        .cfg_beat     (cfg_ch.payload),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one tick beat and hold it until the block takes it.
    task automatic send_tick(input logic [31:0] now, input logic pwr);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        tick_ch.valid   <= 1'b1;
        tick_ch.payload <= {now, pwr};
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
    endtask

    // One register write; valid stays high for a following write.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= {idx, data};
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    // Load all registers; unused upper data bits carry random junk.
    task automatic load_config(input logic [15:0] on_db, input logic [15:0] off_db,
                               input logic [7:0] len, input logic [15:0] gap,
                               input logic [15:0] cool, input logic [31:0] lp_iv,
                               input logic [31:0] norm_iv);
        write_reg(REG_POWER_ON_DEBOUNCE, ($urandom << 16) | on_db);
        write_reg(REG_POWER_OFF_DEBOUNCE, ($urandom << 16) | off_db);
        write_reg(REG_BURST_LENGTH, ($urandom << 8) | len);
        write_reg(REG_BURST_SPACING, ($urandom << 16) | gap);
        write_reg(REG_REARM_COOLDOWN, ($urandom << 16) | cool);
        write_reg(REG_LOW_POWER_INTERVAL, lp_iv);
        write_reg(REG_NORMAL_INTERVAL, norm_iv);
        write_reg(REG_UNMAPPED, $urandom);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop offering ticks, wait for every pending command, then let the
    // last tick finish its evaluation even if it caused nothing.
    task automatic settle();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Power held for random runs with time moving forward, plus stray ticks.
    task automatic run_random(input int count, input int unsigned max_step,
                              input int unsigned max_run);
        int unsigned run_left;
        run_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                send_tick($urandom, 1'($urandom_range(0, 1)));
            end
            else
            begin
                if (run_left == 0)
                begin
                    cur_power = !cur_power;
                    run_left  = $urandom_range(1, max_run);
                end
                cur_time = cur_time + $urandom_range(0, max_step);
                send_tick(cur_time, cur_power);
                run_left--;
            end
        end
    endtask

    // Result receiver: random short stalls and, on request, one long hold-off.
    initial
    begin : receiver
        int unsigned hold_served;
        hold_served     = 0;
        result_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_served)
            begin
                hold_served++;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else if (stall_on && $urandom_range(0, 4) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too many cycles without any beat on any channel.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        wait (rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** power_loss_burst_scheduler: FAILED **");
        $finish;
    end

    initial
    begin
        tick_ch.valid   = 1'b0;
        tick_ch.payload = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.payload  = '0;
        idle_on         = 1'b1;
        stall_on        = 1'b1;
        hold_asks       = 0;
        cur_time        = '0;
        cur_power       = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults. A power-on at time zero never debounces; then a full
        // burst with its cooldown, a normal profile while a burst runs, and a
        // tick that yields normal profile, last send and low-power profile.
        send_tick(32'd0, 1'b1);
        send_tick(32'd20, 1'b1);
        send_tick(32'd30, 1'b0);
        send_tick(32'd35, 1'b0);
        send_tick(32'd40, 1'b0);
        send_tick(32'd79, 1'b0);
        send_tick(32'd80, 1'b0);
        send_tick(32'd115, 1'b1);
        send_tick(32'd125, 1'b1);
        send_tick(32'd130, 1'b0);
        send_tick(32'd140, 1'b0);
        send_tick(32'd700, 1'b0);
        send_tick(32'd705, 1'b1);
        send_tick(32'd715, 1'b1);
        send_tick(32'd740, 1'b1);
        send_tick(32'd770, 1'b0);
        send_tick(32'd771, 1'b1);
        send_tick(32'd781, 1'b1);
        settle();

        // All registers zero: zero-length bursts still set the rearm time,
        // and an off edge at time zero is never seen as set.
        load_config(16'd0, 16'd0, 8'd0, 16'd0, 16'd0, 32'd0, 32'd0);
        send_tick(32'd5, 1'b1);
        send_tick(32'd6, 1'b0);
        send_tick(32'd7, 1'b1);
        send_tick(32'hFFFF_FFFF, 1'b0);
        send_tick(32'hFFFF_FFFF, 1'b1);
        send_tick(32'd0, 1'b0);
        send_tick(32'hFFFF_FFFE, 1'b1);
        settle();

        // Largest settings. Arming just before the time wrap makes the send
        // and rearm times wrap small, so they compare as plain values.
        load_config(16'hFFFF, 16'hFFFF, 8'd2, 16'hFFFF, 16'hFFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_tick(32'hFFFF_0000, 1'b0);
        send_tick(32'hFFFF_FFFF, 1'b0);
        send_tick(32'd5, 1'b0);
        send_tick(32'h0000_FFFE, 1'b0);
        send_tick(32'h0000_FFFF, 1'b0);
        cur_time  = 32'h0002_0000;
        cur_power = 1'b0;
        run_random(15, 70000, 3);
        settle();

        // Everyday settings with well-formed power runs; jump past any
        // send or rearm time left from the large settings first.
        cur_time = cur_time + 140000;
        repeat (2)
        begin
            load_config(16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                        8'($urandom_range(1, 4)), 16'($urandom_range(0, 15)),
                        16'($urandom_range(0, 60)), $urandom, $urandom);
            run_random(14, 6, 12);
            settle();
        end

        // Long receiver hold-off while every power-on edge yields a command,
        // so the output queue fills and the tick channel stalls.
        load_config(16'd0, 16'hFFFF, 8'd1, 16'd0, 16'd0, $urandom, $urandom);
        idle_on   = 1'b0;
        hold_asks <= hold_asks + 1;
        for (int i = 0; i < 16; i++)
        begin
            cur_time = cur_time + 1;
            send_tick(cur_time, (i % 2) == 0);
        end
        settle();

        // Final stretch without idling on either side; longest bursts.
        stall_on = 1'b0;
        load_config(16'($urandom_range(0, 10)), 16'($urandom_range(0, 10)), 8'd255,
                    16'($urandom_range(0, 3)), 16'($urandom), $urandom, $urandom);
        cur_time = cur_time + 70000;
        run_random(20, 4, 8);
        settle();

        if (mismatches == 0)
            $display("** power_loss_burst_scheduler: PASSED **");
        else
            $display("** power_loss_burst_scheduler: FAILED **");
        $finish;
    end

endmodule
